// ===== design/rq_pkg.sv =====
// Shared types, codes and constants for the retransmission queue.
// No dependencies; every other design file but rq_ram imports this package.
`timescale 1ns / 1ps
`default_nettype none

package rq_pkg;

    localparam int DEFAULT_DEPTH = 16;
    localparam int BYTES_W       = 20;
    localparam int COUNT_W       = 5;

    // Operation codes as they arrive on the request word.
    localparam logic [2:0] OP_ADD  = 3'd0;
    localparam logic [2:0] OP_ACK  = 3'd1;
    localparam logic [2:0] OP_EXP  = 3'd2;
    localparam logic [2:0] OP_PEEK = 3'd3;
    localparam logic [2:0] OP_POP  = 3'd4;

    // Status codes reported on every response word.
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    typedef enum logic [2:0] {
        CMD_ADD,
        CMD_ACK,
        CMD_EXP,
        CMD_PEEK,
        CMD_POP,
        CMD_NOP
    } cmd_kind_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DO,
        S_ACK,
        S_SCAN,
        S_EXP_RD,
        S_EXP_OUT,
        S_RDW
    } back_state_t;

    typedef struct packed {
        logic [2:0]  op;
        logic [31:0] seq_start;
        logic [15:0] seg_len;
        logic [15:0] timeout;
        logic [31:0] now;
    } req_t;

    typedef struct packed {
        logic                has_entry;
        logic [31:0]         entry_start;
        logic [15:0]         entry_len;
        logic [31:0]         entry_due;
        logic                last;
        logic [1:0]          status;
        logic [COUNT_W-1:0]  entry_count;
        logic [BYTES_W-1:0]  total_bytes;
    } rsp_t;

    // One stored segment.
    typedef struct packed {
        logic [31:0] start;
        logic [15:0] len;
        logic [31:0] due;
    } entry_t;

    // Classified command handed from the front end to the back end.
    typedef struct packed {
        cmd_kind_t   kind;
        logic [31:0] seq;
        logic [15:0] len;
        logic [31:0] due;
        logic [31:0] now;
    } cmd_t;

endpackage

`default_nettype wire

// ===== design/retransmit_queue_core.sv =====
// Retransmission queue top level. After acceptance, add, unknown codes and expire
// on an empty queue answer straight from the command state, peek and pop after a
// RAM read, acknowledge after a walk over every entry, and expire after a scan that
// stops at the first entry not yet due, then with a RAM read before each word. The
// back end takes its next command in the cycle after its last word is loaded; up to
// two requests wait in front. Async active-low reset empties the queue.
`timescale 1ns / 1ps
`default_nettype none

module retransmit_queue_core
    import rq_pkg::*;
#(
    parameter int DEPTH = DEFAULT_DEPTH
) (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic req_valid,
    output logic      req_ready,
    input  wire req_t req,
    output logic      rsp_valid,
    input  wire logic rsp_ready,
    output rsp_t      rsp
);

    logic cmd_valid;
    logic cmd_ready;
    cmd_t cmd;

    rq_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd)
    );

    rq_back #(
        .DEPTH (DEPTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

endmodule

`default_nettype wire

// ===== design/rq_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module rq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port; read data holds between reads.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ===== design/rq_front.sv =====
// Front end: accepts request words, decodes the operation, computes the due
// time and queues the result in a two-entry command FIFO. Depends on rq_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rq_front
    import rq_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic req_valid,
    output logic      req_ready,
    input  wire req_t req,
    output logic      cmd_valid,
    input  wire logic cmd_ready,
    output cmd_t      cmd
);

    cmd_t       fifo_reg [2];
    logic       wptr_reg;
    logic       rptr_reg;
    logic [1:0] fill_reg;
    cmd_t       dec;
    logic       push;
    logic       pop;

    // Decode the operation code and precompute the due time.
    always_comb
    begin
        dec.seq = req.seq_start;
        dec.len = req.seg_len;
        dec.due = req.now + {16'd0, req.timeout};
        dec.now = req.now;
        case (req.op)
            OP_ADD:  dec.kind = CMD_ADD;
            OP_ACK:  dec.kind = CMD_ACK;
            OP_EXP:  dec.kind = CMD_EXP;
            OP_PEEK: dec.kind = CMD_PEEK;
            OP_POP:  dec.kind = CMD_POP;
            default: dec.kind = CMD_NOP;
        endcase
    end

    assign req_ready = (fill_reg != 2'd2);
    assign push      = req_valid && req_ready;
    assign cmd_valid = (fill_reg != 2'd0);
    assign pop       = cmd_valid && cmd_ready;
    assign cmd       = fifo_reg[rptr_reg];

    // Command FIFO payload.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            fifo_reg[wptr_reg] <= dec;
        end
    end

    // Command FIFO pointers and fill level.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= 1'b0;
            rptr_reg <= 1'b0;
            fill_reg <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wptr_reg <= ~wptr_reg;
            end
            if (pop)
            begin
                rptr_reg <= ~rptr_reg;
            end
            if (push && !pop)
            begin
                fill_reg <= fill_reg + 2'd1;
            end
            else if (pop && !push)
            begin
                fill_reg <= fill_reg - 2'd1;
            end
        end
    end

endmodule

`default_nettype wire

// ===== design/rq_back.sv =====
// Back end: sequencer that owns the segment RAM, the ring pointers and the
// byte total, and drives the response register. Depends on rq_pkg, rq_ram.
`timescale 1ns / 1ps
`default_nettype none

module rq_back
    import rq_pkg::*;
#(
    parameter int DEPTH = DEFAULT_DEPTH
) (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic cmd_valid,
    output logic      cmd_ready,
    input  wire cmd_t cmd,
    output logic      rsp_valid,
    input  wire logic rsp_ready,
    output rsp_t      rsp
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    back_state_t        state_reg, state_next;
    cmd_t               cmd_reg, cmd_next;
    logic [AW-1:0]      head_reg, head_next;
    logic [AW-1:0]      ohead_reg, ohead_next;
    logic [CW-1:0]      count_reg, count_next;
    logic [BYTES_W-1:0] total_reg, total_next;
    logic [CW-1:0]      i_reg, i_next;
    logic [CW-1:0]      kept_reg, kept_next;
    logic [CW-1:0]      pend_reg, pend_next;
    logic [CW-1:0]      k_reg, k_next;
    logic               rv_reg, rv_next;
    logic               stop_reg, stop_next;
    logic               out_valid_reg;
    rsp_t               out_reg;
    rsp_t               res;
    logic               load;
    logic               out_free;
    logic               ram_we;
    logic [AW-1:0]      ram_waddr;
    entry_t             ram_wdata;
    logic               ram_re;
    logic [AW-1:0]      ram_raddr;
    entry_t             rdata;

    // Ring index: base plus offset, wrapped once at DEPTH.
    function automatic logic [AW-1:0] slot(input logic [AW-1:0] base,
                                           input logic [CW-1:0] off);
        logic [CW:0] s;
        s = (CW+1)'(base) + (CW+1)'(off);
        if (s >= (CW+1)'(DEPTH))
        begin
            s = s - (CW+1)'(DEPTH);
        end
        return s[AW-1:0];
    endfunction

    rq_ram #(
        .WIDTH ($bits(entry_t)),
        .DEPTH (DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (rdata)
    );

    assign out_free = !out_valid_reg || rsp_ready;

    // Next state, RAM control and response generation.
    always_comb
    begin
        state_next = state_reg;
        cmd_next   = cmd_reg;
        head_next  = head_reg;
        ohead_next = ohead_reg;
        count_next = count_reg;
        total_next = total_reg;
        i_next     = i_reg;
        kept_next  = kept_reg;
        pend_next  = pend_reg;
        k_next     = k_reg;
        rv_next    = rv_reg;
        stop_next  = stop_reg;
        cmd_ready  = 1'b0;
        load       = 1'b0;
        ram_we     = 1'b0;
        ram_waddr  = '0;
        ram_wdata  = '{start: cmd_reg.seq, len: cmd_reg.len, due: cmd_reg.due};
        ram_re     = 1'b0;
        ram_raddr  = '0;
        res             = '0;
        res.last        = 1'b1;
        res.status      = ST_OK;
        res.entry_count = COUNT_W'(count_reg);
        res.total_bytes = total_reg;

        case (state_reg)
            S_IDLE:
            begin
                cmd_ready = 1'b1;
                if (cmd_valid)
                begin
                    cmd_next   = cmd;
                    state_next = S_DO;
                end
            end

            S_DO:
            begin
                case (cmd_reg.kind)
                    CMD_ADD:
                    begin
                        if (out_free)
                        begin
                            load       = 1'b1;
                            state_next = S_IDLE;
                            if (count_reg == CW'(DEPTH))
                            begin
                                res.status = ST_FULL;
                            end
                            else
                            begin
                                ram_we          = 1'b1;
                                ram_waddr       = slot(head_reg, count_reg);
                                count_next      = count_reg + CW'(1);
                                total_next      = total_reg + BYTES_W'(cmd_reg.len);
                                res.has_entry   = 1'b1;
                                res.entry_start = cmd_reg.seq;
                                res.entry_len   = cmd_reg.len;
                                res.entry_due   = cmd_reg.due;
                                res.entry_count = COUNT_W'(count_next);
                                res.total_bytes = total_next;
                            end
                        end
                    end
                    CMD_ACK:
                    begin
                        i_next     = '0;
                        kept_next  = '0;
                        rv_next    = 1'b0;
                        state_next = S_ACK;
                    end
                    CMD_EXP:
                    begin
                        if (count_reg == '0)
                        begin
                            if (out_free)
                            begin
                                load       = 1'b1;
                                res.status = ST_EMPTY;
                                state_next = S_IDLE;
                            end
                        end
                        else
                        begin
                            i_next     = '0;
                            pend_next  = '0;
                            rv_next    = 1'b0;
                            stop_next  = 1'b0;
                            ohead_next = head_reg;
                            state_next = S_SCAN;
                        end
                    end
                    CMD_PEEK, CMD_POP:
                    begin
                        if (count_reg == '0)
                        begin
                            if (out_free)
                            begin
                                load       = 1'b1;
                                res.status = ST_EMPTY;
                                state_next = S_IDLE;
                            end
                        end
                        else
                        begin
                            ram_re     = 1'b1;
                            ram_raddr  = head_reg;
                            state_next = S_RDW;
                        end
                    end
                    default:
                    begin
                        if (out_free)
                        begin
                            load       = 1'b1;
                            state_next = S_IDLE;
                        end
                    end
                endcase
            end

            // Compaction walk: read one entry a cycle, write kept ones back
            // at the kept position in the cycle after each read.
            S_ACK:
            begin
                rv_next = 1'b0;
                if (i_reg != count_reg)
                begin
                    ram_re    = 1'b1;
                    ram_raddr = slot(head_reg, i_reg);
                    i_next    = i_reg + CW'(1);
                    rv_next   = 1'b1;
                end
                if (rv_reg)
                begin
                    if (rdata.start < cmd_reg.seq)
                    begin
                        total_next = total_reg - BYTES_W'(rdata.len);
                    end
                    else
                    begin
                        ram_we    = 1'b1;
                        ram_waddr = slot(head_reg, kept_reg);
                        ram_wdata = rdata;
                        kept_next = kept_reg + CW'(1);
                    end
                end
                if (i_reg == count_reg && !rv_reg && out_free)
                begin
                    load            = 1'b1;
                    count_next      = kept_reg;
                    res.entry_count = COUNT_W'(kept_reg);
                    state_next      = S_IDLE;
                end
            end

            // Count the due entries at the front before any is reported, so
            // every response carries the final count and total.
            S_SCAN:
            begin
                rv_next = 1'b0;
                if (i_reg != count_reg && !stop_reg)
                begin
                    ram_re    = 1'b1;
                    ram_raddr = slot(head_reg, i_reg);
                    i_next    = i_reg + CW'(1);
                    rv_next   = 1'b1;
                end
                if (rv_reg && !stop_reg)
                begin
                    if (rdata.due <= cmd_reg.now)
                    begin
                        pend_next  = pend_reg + CW'(1);
                        total_next = total_reg - BYTES_W'(rdata.len);
                    end
                    else
                    begin
                        stop_next = 1'b1;
                    end
                end
                if ((i_reg == count_reg || stop_reg) && !rv_reg)
                begin
                    if (pend_reg == '0)
                    begin
                        if (out_free)
                        begin
                            load       = 1'b1;
                            state_next = S_IDLE;
                        end
                    end
                    else
                    begin
                        head_next  = slot(head_reg, pend_reg);
                        count_next = count_reg - pend_reg;
                        k_next     = '0;
                        state_next = S_EXP_RD;
                    end
                end
            end

            S_EXP_RD:
            begin
                ram_re     = 1'b1;
                ram_raddr  = slot(ohead_reg, k_reg);
                state_next = S_EXP_OUT;
            end

            S_EXP_OUT:
            begin
                if (out_free)
                begin
                    load            = 1'b1;
                    res.has_entry   = 1'b1;
                    res.entry_start = rdata.start;
                    res.entry_len   = rdata.len;
                    res.entry_due   = rdata.due;
                    res.last        = (k_reg + CW'(1) == pend_reg);
                    k_next          = k_reg + CW'(1);
                    state_next      = res.last ? S_IDLE : S_EXP_RD;
                end
            end

            S_RDW:
            begin
                if (out_free)
                begin
                    load            = 1'b1;
                    res.has_entry   = 1'b1;
                    res.entry_start = rdata.start;
                    res.entry_len   = rdata.len;
                    res.entry_due   = rdata.due;
                    if (cmd_reg.kind == CMD_POP)
                    begin
                        head_next       = slot(head_reg, CW'(1));
                        count_next      = count_reg - CW'(1);
                        total_next      = total_reg - BYTES_W'(rdata.len);
                        res.entry_count = COUNT_W'(count_next);
                        res.total_bytes = total_next;
                    end
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            head_reg      <= '0;
            count_reg     <= '0;
            total_reg     <= '0;
            rv_reg        <= 1'b0;
            stop_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            head_reg  <= head_next;
            count_reg <= count_next;
            total_reg <= total_next;
            rv_reg    <= rv_next;
            stop_reg  <= stop_next;
            if (load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Working registers and response payload.
    always_ff @(posedge clk)
    begin
        cmd_reg   <= cmd_next;
        ohead_reg <= ohead_next;
        i_reg     <= i_next;
        kept_reg  <= kept_next;
        pend_reg  <= pend_next;
        k_reg     <= k_next;
        if (load)
        begin
            out_reg <= res;
        end
    end

    assign rsp_valid = out_valid_reg;
    assign rsp       = out_reg;

endmodule

`default_nettype wire

// ===== design/rq_checker.sv =====
// Port-level checks for the retransmission queue, bound to the top level.
// Depends on rq_pkg and retransmit_queue_core.
`timescale 1ns / 1ps
`default_nettype none

module rq_checker
    import rq_pkg::*;
#(
    parameter int DEPTH = DEFAULT_DEPTH
) (
    input wire logic clk,
    input wire logic rst_n,
    input wire logic rsp_valid,
    input wire logic rsp_ready,
    input wire rsp_t rsp
);

    // A stalled response word holds.
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
        else $error("response changed while stalled");

    // A dropped add only happens with the queue at capacity.
    a_full: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.status == ST_FULL |->
            !rsp.has_entry && rsp.entry_count == COUNT_W'(DEPTH))
        else $error("full status with queue not full");

    // An empty status reports no entry, no count and no bytes.
    a_empty: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.status == ST_EMPTY |->
            !rsp.has_entry && rsp.entry_count == '0 && rsp.total_bytes == '0)
        else $error("empty status with entries held");

    // Only expire gives multi-word results, and each of those words carries
    // an entry.
    a_multi: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp.last |-> rsp.has_entry && rsp.status == ST_OK)
        else $error("non-final word without an entry");

endmodule

bind retransmit_queue_core rq_checker #(
    .DEPTH (DEPTH)
) u_rq_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
);

`default_nettype wire
